[src/wtm_pkg.sv]
// Package for the window track matcher: sizes, register codes, field widths,
// and the structs that pass between the top level and the matching cells.
// It depends on nothing else.
package wtm_pkg;

    // Table size and the widths that follow from it.
    localparam int REF_DEPTH = 64;
    localparam int CELL_W    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CNT_W     = $clog2(REF_DEPTH + 1);

    // Field widths of the words.
    localparam int PT_W      = 16;
    localparam int ETA_W     = 13;
    localparam int PHI_W     = 16;
    localparam int IDX_W     = 6;
    localparam int ETA_WIN_W = 13;
    localparam int PHI_WIN_W = 15;

    // Operation codes carried in the input tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    // Register indexes, taken from paddr bit 2.
    localparam logic REG_ETA_WINDOW = 1'b0;
    localparam logic REG_PHI_WINDOW = 1'b1;

    // Register reset values.
    localparam logic [ETA_WIN_W-1:0] ETA_WINDOW_RESET = ETA_WIN_W'(164);
    localparam logic [PHI_WIN_W-1:0] PHI_WINDOW_RESET = PHI_WIN_W'(417);

    // Match windows, broadcast to every cell.
    typedef struct packed {
        logic [ETA_WIN_W-1:0] eta_window;
        logic [PHI_WIN_W-1:0] phi_window;
    } cfg_t;

    // Reference load, broadcast to every cell.
    typedef struct packed {
        logic                    we;
        logic                    clear;
        logic [CELL_W-1:0]       idx;
        logic [PT_W-1:0]         pt;
        logic signed [ETA_W-1:0] eta;
        logic [PHI_W-1:0]        phi;
    } load_t;

    // Probe and its running result, handed from cell to cell.
    typedef struct packed {
        logic                    valid;
        logic                    matched;
        logic [IDX_W-1:0]        ref_index;
        logic [PT_W-1:0]         ref_pt;
        logic [PT_W-1:0]         pt;
        logic signed [ETA_W-1:0] eta;
        logic [PHI_W-1:0]        phi;
    } probe_t;

    // Reported index: the low bits of a cell position.
    function automatic logic [IDX_W-1:0] out_index(input logic [CELL_W-1:0] pos);
        logic [CELL_W+IDX_W-1:0] wide;
        wide = (CELL_W + IDX_W)'(pos);
        return wide[IDX_W-1:0];
    endfunction

endpackage

[src/wtm_cell.sv]
// One matching cell: holds a single reference track with its valid and used
// marks, and tests the probe passing through it. Depends on wtm_pkg.
module wtm_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [wtm_pkg::CELL_W-1:0] cell_index,
    input  wtm_pkg::cfg_t         cfg,
    input  wtm_pkg::load_t        load,
    input  wtm_pkg::probe_t       probe_in,
    output wtm_pkg::probe_t       probe_out
);
    import wtm_pkg::*;

    logic                    valid_reg;
    logic                    used_reg;
    logic [PT_W-1:0]         ref_pt_reg;
    logic signed [ETA_W-1:0] ref_eta_reg;
    logic [PHI_W-1:0]        ref_phi_reg;
    probe_t                  probe_reg;

    logic              load_hit;
    logic [PT_W-1:0]   dpt;
    logic [PT_W+3:0]   dpt_x10;
    logic [PHI_W-1:0]  dphi_u;
    logic [PHI_W-1:0]  dphi_mag;
    logic signed [ETA_W:0] deta_s;
    logic [ETA_W:0]    deta_mag;
    logic              pass;
    logic              take;

    assign load_hit = load.we && (load.idx == cell_index);

    // Window tests against the held reference.
    always_comb
    begin
        dpt      = (probe_reg.pt >= ref_pt_reg) ? (probe_reg.pt - ref_pt_reg)
                                                : (ref_pt_reg - probe_reg.pt);
        dpt_x10  = (PT_W + 4)'({dpt, 3'b000}) + (PT_W + 4)'({dpt, 1'b0});
        dphi_u   = probe_reg.phi - ref_phi_reg;
        dphi_mag = dphi_u[PHI_W-1] ? (~dphi_u + PHI_W'(1)) : dphi_u;
        deta_s   = (ETA_W + 1)'(probe_reg.eta) - (ETA_W + 1)'(ref_eta_reg);
        deta_mag = deta_s[ETA_W] ? (ETA_W + 1)'(-deta_s) : (ETA_W + 1)'(deta_s);
        pass     = (dpt_x10 < (PT_W + 4)'(probe_reg.pt))
                && (dphi_mag < PHI_W'(cfg.phi_window))
                && (deta_mag < (ETA_W + 1)'(cfg.eta_window));
    end

    // A waiting probe takes this reference if it is live, unused and in window.
    assign take = probe_reg.valid && !probe_reg.matched && valid_reg && !used_reg && pass;

    always_comb
    begin
        probe_out = probe_reg;
        if (take)
        begin
            probe_out.matched   = 1'b1;
            probe_out.ref_index = out_index(cell_index);
            probe_out.ref_pt    = ref_pt_reg;
        end
    end

    // Valid and used marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            used_reg  <= 1'b0;
        end
        else
        begin
            if (load.clear)
            begin
                valid_reg <= 1'b0;
                used_reg  <= 1'b0;
            end
            if (load_hit)
            begin
                valid_reg <= 1'b1;
                used_reg  <= 1'b0;
            end
            else if (take && advance)
            begin
                used_reg <= 1'b1;
            end
        end
    end

    // Reference payload.
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            ref_pt_reg  <= load.pt;
            ref_eta_reg <= load.eta;
            ref_phi_reg <= load.phi;
        end
    end

    // Probe stage, moved on whenever the row advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else if (advance)
        begin
            probe_reg <= probe_in;
        end
    end

endmodule

[src/window_track_matcher.sv]
// Top level of the window track matcher: stream ports, APB registers, load
// control, the row of matching cells and the output register. Depends on
// wtm_pkg and wtm_cell.

// A load word (tuser op = 0) writes the next free cell; start_event empties
// the table first, and loads beyond REF_DEPTH entries are dropped. A probe
// word (op = 1) walks the row of REF_DEPTH cells, one cell per cycle while
// the row is not stalled, and the first live unused reference inside all
// three windows claims it. One probe is in the row at a time, so no new word
// is taken until the probe has left the row. The result then waits in an
// output register while new words are accepted. Every probe gives one result
// word, loads give none. Registers: eta_window at 0x0, phi_window at 0x4.
module window_track_matcher (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pt[15:0], eta[28:16], phi[44:29], zero[47:45]
    input  logic [1:0]  s_tuser,   // op[0], start_event[1]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // ref_index[5:0], ref_pt[21:6], probe_pt[37:22], zero[39:38]
    output logic        m_tuser,   // matched[0]
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wtm_pkg::*;

    logic [ETA_WIN_W-1:0] eta_window_reg;
    logic [PHI_WIN_W-1:0] phi_window_reg;
    logic [CNT_W-1:0]     ref_count_reg;
    logic [CNT_W-1:0]     ref_count_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    probe_t               out_reg;

    cfg_t                 cfg;
    load_t                load;
    probe_t               chain [0:REF_DEPTH];
    logic [REF_DEPTH-1:0] cell_busy;
    logic                 in_accept;
    logic                 in_op;
    logic                 in_start;
    logic                 last_valid;
    logic                 advance;
    logic                 table_full;
    logic                 cfg_write;

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_ETA_WINDOW: prdata = 32'(eta_window_reg);
            REG_PHI_WINDOW: prdata = 32'(phi_window_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_window_reg <= ETA_WINDOW_RESET;
            phi_window_reg <= PHI_WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_ETA_WINDOW: eta_window_reg <= pwdata[ETA_WIN_W-1:0];
                REG_PHI_WINDOW: phi_window_reg <= pwdata[PHI_WIN_W-1:0];
                default:        eta_window_reg <= eta_window_reg;
            endcase
        end
    end

    assign cfg.eta_window = eta_window_reg;
    assign cfg.phi_window = phi_window_reg;

    // Input handshake: one word at a time while no probe is in the row.
    assign s_tready  = !busy_reg;
    assign in_accept = s_tvalid && s_tready;
    assign in_op     = s_tuser[0];
    assign in_start  = s_tuser[1];

    // Load control and the fill count.
    assign table_full = (ref_count_reg >= CNT_W'(REF_DEPTH));

    always_comb
    begin
        load.clear     = in_accept && (in_op == OP_LOAD) && in_start;
        load.we        = in_accept && (in_op == OP_LOAD) && (in_start || !table_full);
        load.idx       = in_start ? '0 : ref_count_reg[CELL_W-1:0];
        load.pt        = s_tdata[15:0];
        load.eta       = s_tdata[28:16];
        load.phi       = s_tdata[44:29];
        ref_count_next = ref_count_reg;
        if (load.clear)
        begin
            ref_count_next = CNT_W'(1);
        end
        else if (load.we)
        begin
            ref_count_next = ref_count_reg + CNT_W'(1);
        end
    end

    // The probe entering the first cell.
    always_comb
    begin
        chain[0]           = '0;
        chain[0].valid     = in_accept && (in_op == OP_PROBE);
        chain[0].pt        = s_tdata[15:0];
        chain[0].eta       = s_tdata[28:16];
        chain[0].phi       = s_tdata[44:29];
    end

    // The row stalls only while a finished probe cannot enter a full output.
    assign last_valid = chain[REF_DEPTH].valid;
    assign advance    = !(last_valid && out_valid_reg && !m_tready);

    // Row of matching cells.
    for (genvar k = 0; k < REF_DEPTH; k++)
    begin : g_cell
        wtm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .cell_index (CELL_W'(k)),
            .cfg        (cfg),
            .load       (load),
            .probe_in   (chain[k]),
            .probe_out  (chain[k+1])
        );
        assign cell_busy[k] = chain[k+1].valid;
    end

    // Busy flag and output register.
    always_comb
    begin
        busy_next = busy_reg;
        if (chain[0].valid)
        begin
            busy_next = 1'b1;
        end
        else if (last_valid && advance)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (last_valid && advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ref_count_reg <= ref_count_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_valid && advance)
        begin
            out_reg <= chain[REF_DEPTH];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.matched;
    assign m_tdata  = {2'b00, out_reg.pt, out_reg.ref_pt, out_reg.ref_index};

`ifndef NO_ASSERTIONS
    // The busy flag tracks exactly the probe held in the row.
    a_busy_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg == (|cell_busy)) && $onehot0(cell_busy))
        else $error("busy flag disagrees with the probe in the cell row");

    // A result word appears only as the probe leaves the row.
    a_result_from_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $fell(busy_reg))
        else $error("result word without a finishing probe");

    // A stalled probe stays at the end of the row.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (last_valid && !advance) |=> last_valid)
        else $error("stalled probe left the row");
`endif

endmodule
